// ===== rtl/hsl_pkg.sv =====
// hsl_pkg: shared types for the hsl to rgb color converter
// no dependencies; imported by rtl/hsl_to_rgb.sv and tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

   localparam int NUM_CHANNELS = 3;

   // channel order on the result side
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // piecewise segment of the hue-to-channel rule
   typedef enum logic [1:0] {
      REGION_RAMP_UP,
      REGION_HOLD_Q,
      REGION_RAMP_DOWN,
      REGION_HOLD_P
   } region_type;

endpackage

`default_nettype wire

// ===== rtl/hsl_to_rgb.sv =====
// hsl_to_rgb: pipelined hsl to rgb color converter, top level
// depends on rtl/hsl_pkg.sv for the segment type and channel order
`timescale 1ns / 1ps
`default_nettype none

// Converts one HSL color per clock into RGB, unsigned fixed point with
// FRACTION_BITS fraction bits (hue wraps modulo one turn, saturation,
// lightness and the channels run 0 .. 1.0 and inputs above 1.0 are clamped).
// A request is taken at every clock edge with start high; busy stays low, so
// the block sustains one request per cycle. Each result appears for one
// cycle, flagged by rsp_strobe, and must be taken then. The six register
// stages are: input clamp, the lightness times saturation multiply, q and the
// three channel hues, p and the segment choice, the per-channel ramp multiply,
// and the final round and clamp into the output registers. There is no stored
// state beyond the pipeline.
module hsl_to_rgb #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FRACTION_BITS-1:0] req_hue,
   input  logic [FRACTION_BITS:0]   req_saturation,
   input  logic [FRACTION_BITS:0]   req_lightness,
   output logic                     rsp_strobe,
   output logic [FRACTION_BITS:0]   rsp_red,
   output logic [FRACTION_BITS:0]   rsp_green,
   output logic [FRACTION_BITS:0]   rsp_blue
);

   import hsl_pkg::*;

   localparam int Fb          = FRACTION_BITS;
   localparam int Latency     = 6;
   localparam int OneInt      = 1 << FRACTION_BITS;
   localparam int HalfInt     = OneInt / 2;
   localparam int ThirdInt    = (OneInt + 1) / 3;
   localparam int TwoThirdInt = (2 * OneInt + 1) / 3;
   localparam int SixthInt    = (OneInt + 3) / 6;
   localparam int ThirdNegInt = OneInt - ThirdInt;

   localparam logic [Fb:0]     One       = OneInt[Fb:0];
   localparam logic [Fb-1:0]   Half      = HalfInt[Fb-1:0];
   localparam logic [Fb-1:0]   Third     = ThirdInt[Fb-1:0];
   localparam logic [Fb-1:0]   ThirdNeg  = ThirdNegInt[Fb-1:0];
   localparam logic [Fb-1:0]   TwoThird  = TwoThirdInt[Fb-1:0];
   localparam logic [Fb-1:0]   Sixth     = SixthInt[Fb-1:0];
   localparam logic [2*Fb+1:0] HalfWide  = {{(Fb + 2){1'b0}}, Half};

   // valid bits
   logic [Latency-1:0] valid_ff;
   logic [Latency-1:0] valid_in;

   // stage 1
   logic [Fb-1:0] s1_hue_ff, s1_hue_in;
   logic [Fb:0]   s1_sat_ff, s1_sat_in;
   logic [Fb:0]   s1_light_ff, s1_light_in;

   // stage 2
   logic [Fb-1:0]   s2_hue_ff, s2_hue_in;
   logic [Fb:0]     s2_sat_ff, s2_sat_in;
   logic [Fb:0]     s2_light_ff, s2_light_in;
   logic [2*Fb+1:0] s2_prod_ff, s2_prod_in;

   // stage 3
   logic [2*Fb+1:0] s3_round;
   logic [Fb:0]     s3_m;
   logic [Fb+1:0]   s3_q_raw;
   logic [Fb:0]     s3_q_ff, s3_q_in;
   logic [Fb:0]     s3_light_ff, s3_light_in;
   logic [Fb-1:0]   s3_hue_ff [NUM_CHANNELS];
   logic [Fb-1:0]   s3_hue_in [NUM_CHANNELS];

   // stage 4
   logic [Fb+1:0]    s4_twol, s4_q_ext, s4_q_dbl, s4_p_diff, s4_d_diff;
   logic [Fb:0]      s4_p_ff, s4_p_in;
   logic [Fb:0]      s4_q_ff, s4_q_in;
   logic [Fb:0]      s4_d_ff, s4_d_in;
   logic [Fb-1:0]    s4_arg [NUM_CHANNELS];
   logic [Fb+2:0]    s4_arg6 [NUM_CHANNELS];
   region_type       s4_region_ff [NUM_CHANNELS];
   region_type       s4_region_in [NUM_CHANNELS];
   logic [Fb:0]      s4_scale_ff [NUM_CHANNELS];
   logic [Fb:0]      s4_scale_in [NUM_CHANNELS];

   // stage 5
   logic [Fb:0]      s5_p_ff, s5_p_in;
   logic [Fb:0]      s5_q_ff, s5_q_in;
   region_type       s5_region_ff [NUM_CHANNELS];
   region_type       s5_region_in [NUM_CHANNELS];
   logic [2*Fb+1:0]  s5_prod_ff [NUM_CHANNELS];
   logic [2*Fb+1:0]  s5_prod_in [NUM_CHANNELS];

   // stage 6
   logic [2*Fb+1:0]  s6_round [NUM_CHANNELS];
   logic [Fb+2:0]    s6_sum [NUM_CHANNELS];
   logic [Fb:0]      rsp_chan_ff [NUM_CHANNELS];
   logic [Fb:0]      rsp_chan_in [NUM_CHANNELS];

   assign busy = 1'b0;
   assign valid_in = {valid_ff[Latency-2:0], start & ~busy};

   // stage 1: clamp to 1.0
   always_comb begin
      s1_hue_in   = req_hue;
      s1_sat_in   = (req_saturation > One) ? One : req_saturation;
      s1_light_in = (req_lightness > One) ? One : req_lightness;
   end

   // stage 2: lightness times saturation
   always_comb begin
      s2_hue_in   = s1_hue_ff;
      s2_sat_in   = s1_sat_ff;
      s2_light_in = s1_light_ff;
      s2_prod_in  = {{(Fb + 1){1'b0}}, s1_light_ff} * {{(Fb + 1){1'b0}}, s1_sat_ff};
   end

   // stage 3: q and the three channel hues
   always_comb begin
      s3_round = s2_prod_ff + HalfWide;
      s3_m     = s3_round[2*Fb:Fb];
      if (s2_light_ff < {1'b0, Half}) begin
         s3_q_raw = {1'b0, s2_light_ff} + {1'b0, s3_m};
      end else begin
         s3_q_raw = {1'b0, s2_light_ff} + {1'b0, s2_sat_ff} - {1'b0, s3_m};
      end
      s3_q_in = (s3_q_raw > {1'b0, One}) ? One : s3_q_raw[Fb:0];
      s3_light_in = s2_light_ff;
      s3_hue_in[CH_RED]   = s2_hue_ff + Third;
      s3_hue_in[CH_GREEN] = s2_hue_ff;
      s3_hue_in[CH_BLUE]  = s2_hue_ff + ThirdNeg;
   end

   // stage 4: p, q - p and segment per channel
   always_comb begin
      s4_twol   = {s3_light_ff, 1'b0};
      s4_q_ext  = {1'b0, s3_q_ff};
      s4_q_dbl  = {s3_q_ff, 1'b0};
      s4_p_diff = s4_twol - s4_q_ext;
      s4_d_diff = s4_q_dbl - s4_twol;
      s4_q_in   = s3_q_ff;
      priority if (s4_twol < s4_q_ext) begin
         s4_p_in = '0;
         s4_d_in = s3_q_ff;
      end else if (s4_twol > s4_q_dbl) begin
         s4_p_in = s3_q_ff;
         s4_d_in = '0;
      end else begin
         s4_p_in = s4_p_diff[Fb:0];
         s4_d_in = s4_d_diff[Fb:0];
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         priority if (s3_hue_ff[c] < Sixth) begin
            s4_region_in[c] = REGION_RAMP_UP;
            s4_arg[c]       = s3_hue_ff[c];
         end else if (s3_hue_ff[c] < Half) begin
            s4_region_in[c] = REGION_HOLD_Q;
            s4_arg[c]       = '0;
         end else if (s3_hue_ff[c] < TwoThird) begin
            s4_region_in[c] = REGION_RAMP_DOWN;
            s4_arg[c]       = TwoThird - s3_hue_ff[c];
         end else begin
            s4_region_in[c] = REGION_HOLD_P;
            s4_arg[c]       = '0;
         end
         s4_arg6[c]     = {1'b0, s4_arg[c], 2'b00} + {2'b00, s4_arg[c], 1'b0};
         s4_scale_in[c] = s4_arg6[c][Fb:0];
      end
   end

   // stage 5: ramp products
   always_comb begin
      s5_p_in = s4_p_ff;
      s5_q_in = s4_q_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s5_region_in[c] = s4_region_ff[c];
         s5_prod_in[c]   = {{(Fb + 1){1'b0}}, s4_d_ff} * {{(Fb + 1){1'b0}}, s4_scale_ff[c]};
      end
   end

   // stage 6: round, add p, clamp
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s6_round[c] = s5_prod_ff[c] + HalfWide;
         s6_sum[c]   = {2'b00, s5_p_ff} + {1'b0, s6_round[c][2*Fb+1:Fb]};
         unique case (s5_region_ff[c])
            REGION_RAMP_UP, REGION_RAMP_DOWN: begin
               rsp_chan_in[c] = (s6_sum[c] > {2'b00, One}) ? One : s6_sum[c][Fb:0];
            end
            REGION_HOLD_Q: begin
               rsp_chan_in[c] = s5_q_ff;
            end
            REGION_HOLD_P: begin
               rsp_chan_in[c] = s5_p_ff;
            end
            default: begin
               rsp_chan_in[c] = s5_p_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_hue_ff   <= s1_hue_in;
      s1_sat_ff   <= s1_sat_in;
      s1_light_ff <= s1_light_in;
      s2_hue_ff   <= s2_hue_in;
      s2_sat_ff   <= s2_sat_in;
      s2_light_ff <= s2_light_in;
      s2_prod_ff  <= s2_prod_in;
      s3_q_ff     <= s3_q_in;
      s3_light_ff <= s3_light_in;
      s4_p_ff     <= s4_p_in;
      s4_q_ff     <= s4_q_in;
      s4_d_ff     <= s4_d_in;
      s5_p_ff     <= s5_p_in;
      s5_q_ff     <= s5_q_in;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s3_hue_ff[c]    <= s3_hue_in[c];
         s4_region_ff[c] <= s4_region_in[c];
         s4_scale_ff[c]  <= s4_scale_in[c];
         s5_region_ff[c] <= s5_region_in[c];
         s5_prod_ff[c]   <= s5_prod_in[c];
         rsp_chan_ff[c]  <= rsp_chan_in[c];
      end
   end

   assign rsp_strobe = valid_ff[Latency-1];
   assign rsp_red    = rsp_chan_ff[CH_RED];
   assign rsp_green  = rsp_chan_ff[CH_GREEN];
   assign rsp_blue   = rsp_chan_ff[CH_BLUE];

   // every accepted request is followed by a result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_strobe)
      else $error("result missing for an accepted request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, Latency))
      else $error("result without a request");

   // p never exceeds q once clamped
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (s4_p_ff <= s4_q_ff && s4_q_ff <= One))
      else $error("p above q or q above one");

   // channels stay within 0 .. 1.0
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_red <= One && rsp_green <= One && rsp_blue <= One))
      else $error("channel above one");

   // gray input gives equal channels
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_saturation == '0) |-> ##Latency
         (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("gray request gave unequal channels");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for the hsl_to_rgb color converter
// drives hsl requests, predicts each rgb result and compares it channel by channel
// depends on rtl/hsl_pkg.sv and rtl/hsl_to_rgb.sv
`timescale 1ns / 1ps

module tb;
   import hsl_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam longint FX_ONE = longint'(1) << FRAC_BITS;
   localparam longint FX_HALF = FX_ONE / 2;
   localparam longint FX_THIRD = (FX_ONE + 1) / 3;
   localparam longint FX_TWO_THIRDS = (2 * FX_ONE + 1) / 3;
   localparam longint FX_SIXTH = (FX_ONE + 3) / 6;
   localparam int LEVEL_MAX = (1 << (FRAC_BITS + 1)) - 1;
   localparam int HUE_MAX = (1 << FRAC_BITS) - 1;
   localparam int PIPE_LATENCY = 6;
   localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY + 8;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [FRAC_BITS:0] red;
      logic [FRAC_BITS:0] green;
      logic [FRAC_BITS:0] blue;
   } rgb_color_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [FRAC_BITS-1:0] req_hue;
   logic [FRAC_BITS:0]   req_saturation;
   logic [FRAC_BITS:0]   req_lightness;
   logic                 rsp_strobe;
   logic [FRAC_BITS:0]   rsp_red;
   logic [FRAC_BITS:0]   rsp_green;
   logic [FRAC_BITS:0]   rsp_blue;

   rgb_color_type expected_colors[$];
   int            mismatch_count;
   int            request_count;
   int            result_count;
   int            gray_count;
   int            clamped_count;
   int            stall_cycles;

   hsl_to_rgb #(.FRACTION_BITS(FRAC_BITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint fx_round(input longint x);
      return (x + FX_HALF) >>> FRAC_BITS;
   endfunction

   function automatic longint channel_level(input longint p, input longint q, input longint t);
      region_type seg;
      longint     v;
      if (t < FX_SIXTH) seg = REGION_RAMP_UP;
      else if (t < FX_HALF) seg = REGION_HOLD_Q;
      else if (t < FX_TWO_THIRDS) seg = REGION_RAMP_DOWN;
      else seg = REGION_HOLD_P;
      case (seg)
         REGION_RAMP_UP:   v = p + fx_round((q - p) * 6 * t);
         REGION_HOLD_Q:    v = q;
         REGION_RAMP_DOWN: v = p + fx_round((q - p) * 6 * (FX_TWO_THIRDS - t));
         default:          v = p;
      endcase
      return (v > FX_ONE) ? FX_ONE : v;
   endfunction

   // zero saturation falls out of the arithmetic: q = p = lightness
   function automatic rgb_color_type hsl_convert(input logic [FRAC_BITS-1:0] hue,
                                                 input logic [FRAC_BITS:0] sat_in,
                                                 input logic [FRAC_BITS:0] light_in);
      longint        s;
      longint        l;
      longint        q;
      longint        p;
      longint        h;
      rgb_color_type c;
      s = (longint'(sat_in) > FX_ONE) ? FX_ONE : longint'(sat_in);
      l = (longint'(light_in) > FX_ONE) ? FX_ONE : longint'(light_in);
      h = longint'(hue);
      if (l < FX_HALF) q = fx_round(l * (FX_ONE + s));
      else q = l + s - fx_round(l * s);
      if (q < 0) q = 0;
      if (q > FX_ONE) q = FX_ONE;
      p = 2 * l - q;
      if (p < 0) p = 0;
      if (p > q) p = q;
      c.red   = (FRAC_BITS + 1)'(channel_level(p, q, (h + FX_THIRD) % FX_ONE));
      c.green = (FRAC_BITS + 1)'(channel_level(p, q, h));
      c.blue  = (FRAC_BITS + 1)'(channel_level(p, q, (h + FX_ONE - FX_THIRD) % FX_ONE));
      return c;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", what);
   endtask

   task automatic check_channel(input string name, input logic [FRAC_BITS:0] want,
                                input logic [FRAC_BITS:0] got);
      if (got !== want)
         note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // request capture and result checking
   always @(posedge clock) begin
      rgb_color_type want;
      if (!reset) begin
         if (start && !busy) begin
            expected_colors.push_back(hsl_convert(req_hue, req_saturation, req_lightness));
            request_count++;
            if (req_saturation == 0) gray_count++;
            if (req_saturation > FX_ONE || req_lightness > FX_ONE) clamped_count++;
         end
         if (rsp_strobe) begin
            result_count++;
            if (expected_colors.size() == 0) begin
               note_mismatch($sformatf("result with none pending: %0d %0d %0d",
                                       rsp_red, rsp_green, rsp_blue));
            end else begin
               want = expected_colors.pop_front();
               check_channel("red", want.red, rsp_red);
               check_channel("green", want.green, rsp_green);
               check_channel("blue", want.blue, rsp_blue);
            end
         end
      end
   end

   // watchdog on cycles with no request taken and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", stall_cycles);
            $display("hsl_to_rgb verification failed");
            $finish;
         end
      end
   end

   task automatic send_color(input longint hue, input longint sat, input longint light);
      @(negedge clock);
      start          <= 1'b1;
      req_hue        <= FRAC_BITS'(hue);
      req_saturation <= (FRAC_BITS + 1)'(sat);
      req_lightness  <= (FRAC_BITS + 1)'(light);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // noise on the request fields while start is low
   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start          <= 1'b0;
         req_hue        <= FRAC_BITS'($urandom);
         req_saturation <= (FRAC_BITS + 1)'($urandom);
         req_lightness  <= (FRAC_BITS + 1)'($urandom);
      end
   endtask

   function automatic longint pick_level();
      longint v;
      case ($urandom_range(0, 15))
         0:       v = 0;
         1:       v = FX_ONE;
         2:       v = 1;
         3, 4:    v = longint'($urandom_range(LEVEL_MAX, 32'(FX_ONE + 1)));
         5:       v = FX_HALF + longint'($urandom_range(0, 2)) - 1;
         default: v = longint'($urandom_range(0, 32'(FX_ONE)));
      endcase
      return v;
   endfunction

   function automatic longint pick_hue();
      longint edges[5];
      edges = '{0, FX_SIXTH, FX_HALF, FX_TWO_THIRDS, FX_THIRD};
      if ($urandom_range(0, 3) == 0)
         return (edges[$urandom_range(0, 4)] + longint'($urandom_range(0, 4)) - 2) & HUE_MAX;
      return longint'($urandom_range(0, HUE_MAX));
   endfunction

   task automatic test_zero_saturation();
      send_color(0, 0, 0);
      send_color('h1234, 0, FX_ONE);
      send_color(HUE_MAX, 0, FX_HALF);
      send_color('h8000, 0, LEVEL_MAX);
   endtask

   task automatic test_hue_segments();
      longint hues[12];
      hues = '{0, FX_SIXTH - 1, FX_SIXTH, FX_HALF - 1, FX_HALF, FX_TWO_THIRDS - 1,
               FX_TWO_THIRDS, HUE_MAX, FX_THIRD - 1, FX_THIRD, FX_ONE - FX_THIRD - 1, 1};
      foreach (hues[i]) send_color(hues[i], FX_ONE, FX_HALF);
      send_color('h1000, FX_HALF, FX_ONE / 4);
   endtask

   task automatic test_over_range();
      send_color('h2000, LEVEL_MAX, LEVEL_MAX);
      send_color('h5555, FX_ONE + 1, FX_HALF - 1);
      send_color('h0100, 1, 1);
      send_color('hc000, FX_ONE, FX_ONE);
      send_color('h7fff, FX_ONE, 0);
      send_color('h3000, 1, FX_ONE - 1);
      send_color('hffff, FX_ONE, FX_HALF);
   endtask

   task automatic test_random_colors(input int count, input bit with_gaps);
      repeat (count) begin
         if (with_gaps && $urandom_range(0, 7) == 0) idle_for($urandom_range(1, 14));
         send_color(pick_hue(), pick_level(), pick_level());
      end
   endtask

   initial begin
      start          = 1'b0;
      reset          = 1'b1;
      req_hue        = '0;
      req_saturation = '0;
      req_lightness  = '0;
      mismatch_count = 0;
      request_count  = 0;
      result_count   = 0;
      gray_count     = 0;
      clamped_count  = 0;
      stall_cycles   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_saturation();
      test_hue_segments();
      idle_for(3);
      test_over_range();
      test_random_colors(1500, 1'b1);
      test_random_colors(300, 1'b0);

      @(negedge clock);
      start <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_colors.size() != 0) begin
         void'(expected_colors.pop_front());
         note_mismatch("result never arrived");
      end

      $display("covered %0d requests: %0d with zero saturation, %0d with inputs above 1.0",
               request_count, gray_count, clamped_count);
      $display("compared %0d results, %0d mismatches", result_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("hsl_to_rgb verification clean");
      end else begin
         $display("hsl_to_rgb verification failed");
      end
      $finish;
   end

endmodule
